### rtl/lht_pkg.sv
// ----------------------------------------------------------------------------
// lht_pkg
// Shared codes, constants and controller/datapath handshake types for the
// luma histogram and threshold block.
// ----------------------------------------------------------------------------
package lht_pkg;

    // Command codes carried by the func field
    localparam logic [1:0] FUNC_PIXEL = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT    = 2'd1;

    // BT.601 weights scaled by 1000; weighted sum is below 2^18
    localparam int SUM_W = 18;
    localparam logic [SUM_W-1:0] W_RED   = 18'd299;
    localparam logic [SUM_W-1:0] W_GREEN = 18'd587;
    localparam logic [SUM_W-1:0] W_BLUE  = 18'd114;

    // floor(s / 1000) == (s * ceil(2^28 / 1000)) >> 28 for all s below 255001
    localparam int RECIP_W     = 19;
    localparam int RECIP_SHIFT = 28;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 19'd268436;
    localparam int PROD_W = SUM_W + RECIP_W;

    localparam int PIX_W       = 8;
    localparam int OUT_COUNT_W = 24;
    localparam logic [PIX_W-1:0] LEVEL_HIGH = 8'hFF;
    localparam logic [PIX_W-1:0] LEVEL_LOW  = 8'h00;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;    // latch a new request
        logic luma_en;   // form luma from the weighted sum
        logic rd_en;     // read the bin addressed by the request
        logic wr_en;     // write back the updated bin and peak
        logic clr_en;    // zero the bin at the clear pointer and advance
        logic out_load;  // load the result register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_clear;  // latched request is a clear
        logic clr_last;  // clear pointer sits on the last bin
    } t_sts;

endpackage

### rtl/lht_ctrl.sv
// ----------------------------------------------------------------------------
// lht_ctrl
// Sequencer for request intake, bin read-modify-write, the clearing sweep
// and the result handshake.
// ----------------------------------------------------------------------------
module lht_ctrl import lht_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LUMA  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       r_clr_reply, n_clr_reply;
    logic       w_slot_free;
    t_cmd       w_cmd;

    // Result slot frees when empty or being taken this cycle
    assign w_slot_free = !r_out_valid || !i_stall;

    always_comb begin
        w_cmd       = '0;
        n_state     = r_state;
        n_clr_reply = r_clr_reply;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    w_cmd.accept = 1'b1;
                    n_state      = S_LUMA;
                end
            end
            S_LUMA: begin
                w_cmd.luma_en = 1'b1;
                if (i_sts.is_clear) begin
                    n_clr_reply = 1'b1;
                    n_state     = S_CLEAR;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                w_cmd.rd_en = 1'b1;
                n_state     = S_WRITE;
            end
            S_WRITE: begin
                if (w_slot_free) begin
                    w_cmd.wr_en    = 1'b1;
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_CLEAR: begin
                // hold on the last bin until the reply can be posted
                if (!(i_sts.clr_last && r_clr_reply && !w_slot_free)) begin
                    w_cmd.clr_en = 1'b1;
                    if (i_sts.clr_last) begin
                        w_cmd.out_load = r_clr_reply;
                        n_clr_reply    = 1'b0;
                        n_state        = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_out_valid = w_cmd.out_load ? 1'b1 : (r_out_valid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
            r_clr_reply <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_clr_reply <= n_clr_reply;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_cmd   = w_cmd;

    // A held result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !(r_out_valid && i_stall))
        else $error("result register overwritten while stalled");

    // An accepted request always moves on to luma
    a_accept_luma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_LUMA))
        else $error("accepted request did not enter luma stage");

    // Luma is followed by a bin read or a clearing sweep
    a_luma_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LUMA) |=> (r_state == S_READ || r_state == S_CLEAR))
        else $error("bad state after luma stage");

    // A memory write never coincides with the clearing sweep
    a_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.wr_en && w_cmd.clr_en))
        else $error("two histogram writes in one cycle");

endmodule

### rtl/lht_datapath.sv
// ----------------------------------------------------------------------------
// lht_datapath
// Luma arithmetic, threshold, histogram store, peak tracking and the
// result register.
// ----------------------------------------------------------------------------
module lht_datapath import lht_pkg::*; #(
    parameter int HIST_BINS   = 256,
    parameter int COUNT_WIDTH = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    input  logic [PIX_W-1:0]       i_threshold,
    input  logic                   i_invert,
    input  logic [1:0]             i_func,
    input  logic [PIX_W-1:0]       i_red,
    input  logic [PIX_W-1:0]       i_green,
    input  logic [PIX_W-1:0]       i_blue,
    input  logic [PIX_W-1:0]       i_bin_index,
    output logic [PIX_W-1:0]       o_luma,
    output logic [PIX_W-1:0]       o_binary_level,
    output logic [OUT_COUNT_W-1:0] o_bin_count,
    output logic [OUT_COUNT_W-1:0] o_peak_count
);

    localparam int BIN_W = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1;
    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(HIST_BINS - 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] r_hist [HIST_BINS];

    logic [1:0]             r_func;
    logic [PIX_W-1:0]       r_idx;
    logic [SUM_W-1:0]       r_sum;
    logic [PIX_W-1:0]       r_luma;
    logic [BIN_W-1:0]       r_addr;
    logic                   r_oob;
    logic [COUNT_WIDTH-1:0] r_rd;
    logic [COUNT_WIDTH-1:0] r_peak;
    logic [BIN_W-1:0]       r_clr_ptr;

    logic [PIX_W-1:0]       r_out_luma;
    logic [PIX_W-1:0]       r_out_level;
    logic [COUNT_WIDTH-1:0] r_out_count;
    logic [COUNT_WIDTH-1:0] r_out_peak;

    logic [SUM_W-1:0]       w_sum;
    logic [PROD_W-1:0]      w_prod;
    logic [BIN_W-1:0]       w_addr;
    logic                   w_pixel;
    logic [COUNT_WIDTH-1:0] w_inc;
    logic [COUNT_WIDTH-1:0] w_peak_next;
    logic [PIX_W-1:0]       w_level;

    assign w_sum = SUM_W'(i_red) * W_RED + SUM_W'(i_green) * W_GREEN
                 + SUM_W'(i_blue) * W_BLUE;
    assign w_prod = PROD_W'(r_sum) * PROD_W'(RECIP_1000);

    // Pixel bin clamps to the last bin when the luma lies beyond the store
    always_comb begin
        if (r_func == FUNC_READ) begin
            w_addr = BIN_W'(r_idx);
        end else if (32'(r_luma) < HIST_BINS) begin
            w_addr = BIN_W'(r_luma);
        end else begin
            w_addr = LAST_BIN;
        end
    end

    assign w_pixel     = (r_func == FUNC_PIXEL);
    assign w_inc       = (r_rd == COUNT_MAX) ? r_rd : r_rd + COUNT_WIDTH'(1);
    assign w_peak_next = (w_inc > r_peak) ? w_inc : r_peak;
    assign w_level     = ((r_luma > i_threshold) ^ i_invert) ? LEVEL_HIGH : LEVEL_LOW;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func <= i_func;
            r_idx  <= i_bin_index;
            r_sum  <= w_sum;
        end
        if (i_cmd.luma_en) begin
            r_luma <= PIX_W'(w_prod >> RECIP_SHIFT);
        end
        if (i_cmd.rd_en) begin
            r_addr <= w_addr;
            r_oob  <= (32'(r_idx) >= HIST_BINS);
        end
    end

    // Histogram store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_en) begin
            r_hist[r_clr_ptr] <= '0;
        end else if (i_cmd.wr_en && w_pixel) begin
            r_hist[r_addr] <= w_inc;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_hist[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak    <= '0;
            r_clr_ptr <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_ptr <= (r_clr_ptr == LAST_BIN) ? '0 : r_clr_ptr + BIN_W'(1);
            if (r_clr_ptr == LAST_BIN) begin
                r_peak <= '0;
            end
        end else if (i_cmd.wr_en && w_pixel) begin
            r_peak <= w_peak_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            unique case (r_func)
                FUNC_PIXEL: begin
                    r_out_luma  <= r_luma;
                    r_out_level <= w_level;
                    r_out_count <= w_inc;
                    r_out_peak  <= w_peak_next;
                end
                FUNC_READ: begin
                    r_out_luma  <= '0;
                    r_out_level <= '0;
                    r_out_count <= r_oob ? '0 : r_rd;
                    r_out_peak  <= r_peak;
                end
                FUNC_CLEAR: begin
                    r_out_luma  <= '0;
                    r_out_level <= '0;
                    r_out_count <= '0;
                    r_out_peak  <= '0;
                end
                default: begin
                    r_out_luma  <= '0;
                    r_out_level <= '0;
                    r_out_count <= '0;
                    r_out_peak  <= r_peak;
                end
            endcase
        end
    end

    assign o_sts.is_clear = (r_func == FUNC_CLEAR);
    assign o_sts.clr_last = (r_clr_ptr == LAST_BIN);

    assign o_luma         = r_out_luma;
    assign o_binary_level = r_out_level;
    assign o_bin_count    = OUT_COUNT_W'(32'(r_out_count));
    assign o_peak_count   = OUT_COUNT_W'(32'(r_out_peak));

endmodule

### rtl/luma_histogram_threshold.sv
// ----------------------------------------------------------------------------
// luma_histogram_threshold
// BT.601 luma with binary threshold, saturating luma histogram and peak.
// ----------------------------------------------------------------------------
// Each request is a pixel (func 0), a bin read (func 1) or a histogram clear
// (func 2); every request returns exactly one result. A pixel yields its luma
// floor((299r + 587g + 114b) / 1000), a binary level of 255 or 0 (luma above
// the threshold gives 255, swapped when invert is set), and counts into bin
// luma, saturating at 2^COUNT_WIDTH - 1; the result carries the new bin
// count and the running peak. Pixel and read requests pass through intake,
// luma multiply, registered histogram read, then write-back and result load;
// the bin store has one write port and one registered read port. A clear
// walks the store one bin per cycle, holding on the last bin while a held
// result is stalled. After reset the same sweep runs over every bin before
// the first request is taken, with no result produced. Configuration writes
// are always ready and should be issued only while no request is in flight.
// ----------------------------------------------------------------------------
module luma_histogram_threshold import lht_pkg::*; #(
    parameter int HIST_BINS   = 256,
    parameter int COUNT_WIDTH = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request channel
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [1:0]             i_func,
    input  logic [PIX_W-1:0]       i_red,
    input  logic [PIX_W-1:0]       i_green,
    input  logic [PIX_W-1:0]       i_blue,
    input  logic [PIX_W-1:0]       i_bin_index,
    // result channel
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [PIX_W-1:0]       o_luma,
    output logic [PIX_W-1:0]       o_binary_level,
    output logic [OUT_COUNT_W-1:0] o_bin_count,
    output logic [OUT_COUNT_W-1:0] o_peak_count,
    // configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [PIX_W-1:0]       i_cfg_data
);

    logic [PIX_W-1:0] r_threshold;
    logic             r_invert;
    t_cmd             w_cmd;
    t_sts             w_sts;

    // Configuration registers; writes land immediately
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= 8'd128;
            r_invert    <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD: r_threshold <= i_cfg_data;
                CFG_INVERT:    r_invert    <= i_cfg_data[0];
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    // Sequencer: intake, read-modify-write and clearing sweep
    lht_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Arithmetic, histogram store and result register
    lht_datapath #(
        .HIST_BINS   (HIST_BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_threshold    (r_threshold),
        .i_invert       (r_invert),
        .i_func         (i_func),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_bin_index    (i_bin_index),
        .o_luma         (o_luma),
        .o_binary_level (o_binary_level),
        .o_bin_count    (o_bin_count),
        .o_peak_count   (o_peak_count)
    );

endmodule

### test/luma_histogram_threshold_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// luma_histogram_threshold_test
// Self-checking bench for the luma, threshold and histogram block. A short
// table of directed requests opens the run, then seven phases of random
// requests follow, each under its own threshold and invert setting. Every
// accepted request is run through a local model of the bin store and peak,
// and each result is checked against the oldest prediction in the queue.
// ----------------------------------------------------------------------------
module luma_histogram_threshold_test import lht_pkg::*;;

    // Run the block at its default sizes.
    localparam int HIST_BINS   = 256;
    localparam int COUNT_WIDTH = 24;
    localparam int unsigned COUNT_MAX = (1 << COUNT_WIDTH) - 1;

    // Spare command code: the block must leave its state alone
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    localparam int PHASES         = 7;
    localparam int STEADY_PHASE   = 2;  // no idling on either side
    localparam int SATURATE_PHASE = 3;  // one hot color, no clears
    localparam int HOLD_PHASE     = 5;  // receiver holds off for a long stretch
    localparam int HOLD_CYCLES    = 300;
    localparam int DIRECTED_ROWS  = 20;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [PIX_W-1:0]       luma;
        logic [PIX_W-1:0]       level;
        logic [OUT_COUNT_W-1:0] bin_count;
        logic [OUT_COUNT_W-1:0] peak;
    } t_luma_result;

    typedef struct packed {
        logic [1:0]       func;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] bin_index;
        logic             known;   // expected result typed in below
        t_luma_result     want;
    } t_luma_row;

    // Directed requests, all under the reset setting (threshold 128, no invert).
    t_luma_row directed_rows [DIRECTED_ROWS] = '{
        // fresh store reads zero
        '{FUNC_READ,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1, '{8'h00, 8'h00, 24'd0, 24'd0}},
        // black and white pixels, extremes of luma
        '{FUNC_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, '{8'h00, 8'h00, 24'd1, 24'd1}},
        '{FUNC_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1, '{8'hFF, 8'hFF, 24'd1, 24'd1}},
        '{FUNC_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1, '{8'hFF, 8'hFF, 24'd2, 24'd2}},
        '{FUNC_READ,  8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, '{8'h00, 8'h00, 24'd2, 24'd2}},
        '{FUNC_READ,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1, '{8'h00, 8'h00, 24'd1, 24'd2}},
        // spare code returns the current peak only
        '{FUNC_SPARE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{8'h00, 8'h00, 24'd0, 24'd2}},
        // single primaries
        '{FUNC_PIXEL, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, '0},
        '{FUNC_PIXEL, 8'h00, 8'hFF, 8'h00, 8'h00, 1'b0, '0},
        '{FUNC_PIXEL, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b0, '0},
        // luma exactly at the threshold stays low, one above goes high
        '{FUNC_PIXEL, 8'h80, 8'h80, 8'h80, 8'h00, 1'b0, '0},
        '{FUNC_PIXEL, 8'h81, 8'h81, 8'h81, 8'h00, 1'b0, '0},
        '{FUNC_PIXEL, 8'hAA, 8'h55, 8'hAA, 8'h00, 1'b0, '0},
        '{FUNC_READ,  8'h00, 8'h00, 8'h00, 8'hAA, 1'b0, '0},
        '{FUNC_READ,  8'h00, 8'h00, 8'h00, 8'h55, 1'b0, '0},
        '{FUNC_SPARE, 8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0, '0},
        // clear ignores its payload and zeroes everything
        '{FUNC_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{8'h00, 8'h00, 24'd0, 24'd0}},
        '{FUNC_READ,  8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, '{8'h00, 8'h00, 24'd0, 24'd0}},
        '{FUNC_PIXEL, 8'h80, 8'h80, 8'h80, 8'h00, 1'b0, '0},
        '{FUNC_READ,  8'h00, 8'h00, 8'h00, 8'h80, 1'b0, '0}
    };

    int phase_len [PHASES] = '{250, 250, 250, 500, 250, 250, 250};

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    logic [1:0]             i_func;
    logic [PIX_W-1:0]       i_red;
    logic [PIX_W-1:0]       i_green;
    logic [PIX_W-1:0]       i_blue;
    logic [PIX_W-1:0]       i_bin_index;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [PIX_W-1:0]       o_luma;
    logic [PIX_W-1:0]       o_binary_level;
    logic [OUT_COUNT_W-1:0] o_bin_count;
    logic [OUT_COUNT_W-1:0] o_peak_count;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [PIX_W-1:0]       i_cfg_data;

    // Local copy of the block's state and settings
    int unsigned      bin_tally [HIST_BINS];
    int unsigned      peak_tally;
    logic [PIX_W-1:0] cfg_threshold;
    logic             cfg_invert;

    t_luma_result awaited_results [$];
    int           fault_count = 0;
    int           phase_no    = -1;
    bit           steady      = 1'b0;
    int           hold_left   = 0;
    bit           hold_done   = 1'b0;

    luma_histogram_threshold #(
        .HIST_BINS   (HIST_BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one request to the local model and return what the block owes.
    task automatic tally_request(input logic [1:0] func, input logic [PIX_W-1:0] red,
                                 input logic [PIX_W-1:0] green, input logic [PIX_W-1:0] blue,
                                 input logic [PIX_W-1:0] bin_index, output t_luma_result res);
        int unsigned weighted;
        int unsigned slot;
        res = '0;
        case (func)
            FUNC_PIXEL: begin
                // BT.601 weights scaled by 1000, floor division
                weighted = 299 * red + 587 * green + 114 * blue;
                res.luma = PIX_W'(weighted / 1000);
                res.level = ((res.luma > cfg_threshold) ^ cfg_invert) ? LEVEL_HIGH : LEVEL_LOW;
                // lumas past the last bin land in the last bin
                slot = (res.luma < HIST_BINS) ? res.luma : HIST_BINS - 1;
                if (bin_tally[slot] < COUNT_MAX)
                    bin_tally[slot]++;
                res.bin_count = OUT_COUNT_W'(bin_tally[slot]);
                if (bin_tally[slot] > peak_tally)
                    peak_tally = bin_tally[slot];
            end
            FUNC_READ: begin
                if (bin_index < HIST_BINS)
                    res.bin_count = OUT_COUNT_W'(bin_tally[bin_index]);
            end
            FUNC_CLEAR: begin
                foreach (bin_tally[i])
                    bin_tally[i] = 0;
                peak_tally = 0;
            end
            default: ;
        endcase
        res.peak = OUT_COUNT_W'(peak_tally);
    endtask

    // Offer one request, hold it until taken, then predict its result.
    task automatic push_request(input logic [1:0] func, input logic [PIX_W-1:0] red,
                                input logic [PIX_W-1:0] green, input logic [PIX_W-1:0] blue,
                                input logic [PIX_W-1:0] bin_index, input logic known,
                                input t_luma_result want);
        t_luma_result predicted;
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < 21) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_func      = func;
        i_red       = red;
        i_green     = green;
        i_blue      = blue;
        i_bin_index = bin_index;
        i_valid     = 1'b1;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        tally_request(func, red, green, blue, bin_index, predicted);
        awaited_results.push_back(known ? want : predicted);
    endtask

    // Drop valid and wait until every result has come back.
    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [PIX_W-1:0] data);
        @(negedge i_clk);
        i_cfg_index = index;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        if (index == CFG_THRESHOLD)
            cfg_threshold = data;
        else
            cfg_invert = data[0];
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Result side: stall at random, hold off once for a long stretch so the
    // block backs up into its request port, and never stall in the steady phase.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
        end else if (phase_no == HOLD_PHASE && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        i_stall = (hold_left != 0) || (!steady && $urandom_range(99) < 21);
    end

    // Check each accepted result against the oldest prediction.
    always @(posedge i_clk) begin : check_result
        t_luma_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_results.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("unexpected result: luma %0d level %0d count %0d peak %0d",
                             o_luma, o_binary_level, o_bin_count, o_peak_count);
            end else begin
                want = awaited_results.pop_front();
                if (o_luma !== want.luma || o_binary_level !== want.level ||
                    o_bin_count !== want.bin_count || o_peak_count !== want.peak) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display({"mismatch: luma %0d/%0d level %0d/%0d count %0d/%0d",
                                  " peak %0d/%0d (expected/actual)"},
                                 want.luma, o_luma, want.level, o_binary_level,
                                 want.bin_count, o_bin_count, want.peak, o_peak_count);
                end
            end
        end
    end

    // Give up on a hang, with the worst case taken several times over.
    initial begin
        #50000000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        logic [1:0]       func;
        logic [PIX_W-1:0] red, green, blue, bin_index;
        logic [PIX_W-1:0] hot_red, hot_green, hot_blue;
        int               pick;

        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_func      = FUNC_PIXEL;
        i_red       = '0;
        i_green     = '0;
        i_blue      = '0;
        i_bin_index = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_THRESHOLD;
        i_cfg_data  = '0;
        foreach (bin_tally[i])
            bin_tally[i] = 0;
        peak_tally    = 0;
        cfg_threshold = 8'd128;
        cfg_invert    = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i])
            push_request(directed_rows[i].func, directed_rows[i].red,
                         directed_rows[i].green, directed_rows[i].blue,
                         directed_rows[i].bin_index, directed_rows[i].known,
                         directed_rows[i].want);
        drain();

        hot_red   = PIX_W'($urandom_range(255));
        hot_green = PIX_W'($urandom_range(255));
        hot_blue  = PIX_W'($urandom_range(255));

        for (int p = 0; p < PHASES; p++) begin
            // Walk the settings through both extremes first, then random ones.
            case (p)
                0: begin
                    write_register(CFG_THRESHOLD, 8'd0);
                    write_register(CFG_INVERT, 8'd0);
                end
                1: begin
                    write_register(CFG_THRESHOLD, 8'd255);
                    write_register(CFG_INVERT, 8'd1);
                end
                2: begin
                    write_register(CFG_THRESHOLD, 8'd0);
                    write_register(CFG_INVERT, 8'd1);
                end
                3: begin
                    write_register(CFG_THRESHOLD, 8'd255);
                    write_register(CFG_INVERT, 8'd0);
                end
                default: begin
                    write_register(CFG_THRESHOLD, PIX_W'($urandom_range(255)));
                    write_register(CFG_INVERT, PIX_W'($urandom_range(1)));
                end
            endcase
            phase_no = p;
            steady   = (p == STEADY_PHASE);

            for (int n = 0; n < phase_len[p]; n++) begin
                pick      = $urandom_range(99);
                red       = PIX_W'($urandom_range(255));
                green     = PIX_W'($urandom_range(255));
                blue      = PIX_W'($urandom_range(255));
                bin_index = PIX_W'($urandom_range(255));
                if (pick < 1 && p != SATURATE_PHASE) begin
                    func = FUNC_CLEAR;
                end else if (pick < 11) begin
                    func = FUNC_READ;
                end else if (pick < 14) begin
                    func = FUNC_SPARE;
                end else begin
                    func = FUNC_PIXEL;
                    if (p == SATURATE_PHASE && $urandom_range(99) < 80) begin
                        // pile into one bin to push up the peak
                        red   = hot_red;
                        green = hot_green;
                        blue  = hot_blue;
                    end else if ($urandom_range(9) == 0) begin
                        // corner colors reach the extreme lumas
                        red   = $urandom_range(1) ? 8'hFF : 8'h00;
                        green = $urandom_range(1) ? 8'hFF : 8'h00;
                        blue  = $urandom_range(1) ? 8'hFF : 8'h00;
                    end
                end
                push_request(func, red, green, blue, bin_index, 1'b0, '0);
            end
            drain();
            steady = 1'b0;
        end

        // Let a late or extra result show up before judging the run.
        repeat (HIST_BINS + 8) @(posedge i_clk);
        if (fault_count == 0 && awaited_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
